>>> rtl/i2cms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types, opcodes and sequence lengths for the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [7:0]  MSB_MASK    = 8'h80;

    typedef struct packed {
        t_op        op;
        logic       cmd_nz;
        logic [7:0] wr_data;
        logic       ack_out;
        logic       sda_in;
    } t_slot_req;

    function automatic logic [4:0] seq_len(input t_op op);
        logic [4:0] len;
        case (op)
            OP_START: len = 5'd4;
            OP_STOP:  len = 5'd3;
            OP_WRITE: len = 5'd24;
            OP_READ:  len = 5'd25;
            OP_SACK:  len = 5'd3;
            OP_RACK:  len = 5'd4;
            default:  len = 5'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> rtl/i2cms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_front
// accepts slot requests, decodes the command code and registers the request
// ----------------------------------------------------------------------------
module i2cms_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [2:0]            i_cmd,
    input  wire  [7:0]            i_wr_data,
    input  wire                   i_ack_out,
    input  wire                   i_sda_in,
    output logic                  o_req_valid,
    output i2cms_pkg::t_slot_req  o_req,
    input  wire                   i_req_stall
);

    logic                 r_valid;
    i2cms_pkg::t_slot_req r_req;
    i2cms_pkg::t_slot_req n_req;
    logic                 take;

    always_comb begin
        n_req.cmd_nz  = (i_cmd != i2cms_pkg::OP_IDLE);
        n_req.wr_data = i_wr_data;
        n_req.ack_out = i_ack_out;
        n_req.sda_in  = i_sda_in;
        case (i_cmd)
            i2cms_pkg::OP_START: n_req.op = i2cms_pkg::OP_START;
            i2cms_pkg::OP_STOP:  n_req.op = i2cms_pkg::OP_STOP;
            i2cms_pkg::OP_WRITE: n_req.op = i2cms_pkg::OP_WRITE;
            i2cms_pkg::OP_READ:  n_req.op = i2cms_pkg::OP_READ;
            i2cms_pkg::OP_SACK:  n_req.op = i2cms_pkg::OP_SACK;
            i2cms_pkg::OP_RACK:  n_req.op = i2cms_pkg::OP_RACK;
            default:             n_req.op = i2cms_pkg::OP_IDLE;
        endcase
    end

    assign o_stall     = r_valid && i_req_stall;
    assign take        = i_valid && !o_stall;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= n_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/i2cms_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_queue
// small first-in first-out buffer of requests between front and back
// ----------------------------------------------------------------------------
module i2cms_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push_valid,
    output logic                  o_push_stall,
    input  i2cms_pkg::t_slot_req  i_push_req,
    output logic                  o_pop_valid,
    input  wire                   i_pop_stall,
    output i2cms_pkg::t_slot_req  o_pop_req
);

    i2cms_pkg::t_slot_req               r_mem [i2cms_pkg::QUEUE_DEPTH];
    logic [i2cms_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [i2cms_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [i2cms_pkg::QUEUE_AW:0]       r_count;
    logic                               push;
    logic                               pop;

    assign o_push_stall = (r_count == (i2cms_pkg::QUEUE_AW+1)'(i2cms_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_req    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = o_pop_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/i2cms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_back
// runs the pin sequences one slot per request and holds the result register
// ----------------------------------------------------------------------------
module i2cms_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    output logic                  o_req_stall,
    input  i2cms_pkg::t_slot_req  i_req,
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic                  o_scl,
    output logic                  o_sda_drive,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rd_data,
    output logic                  o_ack_in,
    output logic                  o_rejected
);

    i2cms_pkg::t_op r_op;
    i2cms_pkg::t_op n_op;
    i2cms_pkg::t_op cur_op;
    logic [4:0]     r_slot, n_slot, cur_slot;
    logic [1:0]     r_phase, n_phase, cur_phase;
    logic [2:0]     r_bit, n_bit, cur_bit;
    logic [7:0]     r_shift, n_shift, cur_shift;
    logic           r_scl, n_scl;
    logic           r_sda, n_sda;
    logic           r_ack, n_ack;
    logic [7:0]     r_rd, n_rd;
    logic           r_done, n_done;
    logic           r_rej, n_rej;
    logic           r_out_valid;
    logic           pop;
    logic           start_cmd;
    logic           last_slot;
    logic           bit_step;
    logic [7:0]     bit_mask;

    assign o_req_stall = r_out_valid && i_stall;
    assign pop         = i_req_valid && !o_req_stall;

    // command pickup while idle
    always_comb begin
        start_cmd = (r_op == i2cms_pkg::OP_IDLE) && (i_req.op != i2cms_pkg::OP_IDLE);
        n_rej     = (r_op != i2cms_pkg::OP_IDLE) && i_req.cmd_nz;
        if (start_cmd) begin
            cur_op    = i_req.op;
            cur_slot  = 5'd0;
            cur_phase = 2'd0;
            cur_bit   = 3'd0;
            cur_shift = (i_req.op == i2cms_pkg::OP_WRITE) ? i_req.wr_data : 8'd0;
        end else begin
            cur_op    = r_op;
            cur_slot  = r_slot;
            cur_phase = r_phase;
            cur_bit   = r_bit;
            cur_shift = r_shift;
        end
        bit_mask = i2cms_pkg::MSB_MASK >> cur_bit;
    end

    // line actions of the current slot
    always_comb begin
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_shift = cur_shift;
        case (cur_op)
            i2cms_pkg::OP_START: begin
                case (cur_slot[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: n_scl = 1'b0;
                endcase
            end
            i2cms_pkg::OP_STOP: begin
                case (cur_slot[1:0])
                    2'd0:    n_sda = 1'b0;
                    2'd1:    n_scl = 1'b1;
                    default: n_sda = 1'b1;
                endcase
            end
            i2cms_pkg::OP_WRITE: begin
                case (cur_phase)
                    2'd0:    n_sda = |(cur_shift & bit_mask);
                    2'd1:    n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            i2cms_pkg::OP_READ: begin
                if (cur_slot == 5'd0) begin
                    n_sda = 1'b1;
                end else begin
                    case (cur_phase)
                        2'd0:    n_scl = 1'b1;
                        2'd1:    n_shift = i_req.sda_in ? (cur_shift | bit_mask) : cur_shift;
                        default: n_scl = 1'b0;
                    endcase
                end
            end
            i2cms_pkg::OP_SACK: begin
                case (cur_slot[1:0])
                    2'd0:    n_sda = i_req.ack_out;
                    2'd1:    n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
            end
            i2cms_pkg::OP_RACK: begin
                case (cur_slot[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_ack = i_req.sda_in;
                    default: n_scl = 1'b0;
                endcase
            end
            default: begin
                n_scl = r_scl;
            end
        endcase
    end

    // slot sequencing
    always_comb begin
        last_slot = ({1'b0, cur_slot} + 6'd1) >= {1'b0, i2cms_pkg::seq_len(cur_op)};
        bit_step  = !((cur_op == i2cms_pkg::OP_READ) && (cur_slot == 5'd0));
        n_done    = 1'b0;
        n_rd      = r_rd;
        n_op      = cur_op;
        n_slot    = cur_slot;
        n_phase   = cur_phase;
        n_bit     = cur_bit;
        if (cur_op != i2cms_pkg::OP_IDLE) begin
            if (last_slot) begin
                n_done  = 1'b1;
                n_op    = i2cms_pkg::OP_IDLE;
                n_slot  = 5'd0;
                n_phase = 2'd0;
                n_bit   = 3'd0;
                if (cur_op == i2cms_pkg::OP_READ) begin
                    n_rd = n_shift;
                end
            end else begin
                n_slot = cur_slot + 5'd1;
                if (bit_step) begin
                    if (cur_phase == 2'd2) begin
                        n_phase = 2'd0;
                        n_bit   = cur_bit + 3'd1;
                    end else begin
                        n_phase = cur_phase + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= i2cms_pkg::OP_IDLE;
            r_slot      <= 5'd0;
            r_phase     <= 2'd0;
            r_bit       <= 3'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b0;
            r_rd        <= 8'd0;
            r_done      <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_op    <= n_op;
                r_slot  <= n_slot;
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_ack   <= n_ack;
                r_rd    <= n_rd;
                r_done  <= n_done;
                r_rej   <= n_rej;
            end
            if (!o_req_stall) begin
                r_out_valid <= i_req_valid;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl       = r_scl;
    assign o_sda_drive = r_sda;
    assign o_busy_res  = (r_op != i2cms_pkg::OP_IDLE);
    assign o_done_res  = r_done;
    assign o_rd_data   = r_rd;
    assign o_ack_in    = r_ack;
    assign o_rejected  = r_rej;

endmodule
`default_nettype wire

>>> rtl/i2c_master_bit_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// i2c master bit engine: one request is one pin-timing slot
// ----------------------------------------------------------------------------
// Every request is one timing slot and yields exactly one result carrying the
// SCL and SDA drive levels after that slot, busy/done flags, the latest read
// byte and received ack, and a flag for a command refused while busy. A
// command is taken only when the engine is idle and its first step runs in
// the same slot. Throughput is one request per clock while the result side
// does not stall; input reaches the result through the front register, the
// four-entry queue and the result register. The queue lets the input side
// keep running for a few slots while the result side is stalled.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [2:0] i_cmd,
    input  wire  [7:0] i_wr_data,
    input  wire        i_ack_out,
    input  wire        i_sda_in,
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_scl,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rd_data,
    output logic       o_ack_in,
    output logic       o_rejected
);

    logic                 front_valid;
    logic                 front_stall;
    i2cms_pkg::t_slot_req front_req;
    logic                 queue_valid;
    logic                 queue_stall;
    i2cms_pkg::t_slot_req queue_req;

    i2cms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_wr_data   (i_wr_data),
        .i_ack_out   (i_ack_out),
        .i_sda_in    (i_sda_in),
        .o_req_valid (front_valid),
        .o_req       (front_req),
        .i_req_stall (front_stall)
    );

    i2cms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_stall (front_stall),
        .i_push_req   (front_req),
        .o_pop_valid  (queue_valid),
        .i_pop_stall  (queue_stall),
        .o_pop_req    (queue_req)
    );

    i2cms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (queue_valid),
        .o_req_stall (queue_stall),
        .i_req       (queue_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl       (o_scl),
        .o_sda_drive (o_sda_drive),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rd_data   (o_rd_data),
        .o_ack_in    (o_ack_in),
        .o_rejected  (o_rejected)
    );

endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the i2c master bit sequencer
// ----------------------------------------------------------------------------
// Each request is one pin-timing slot. The bench runs its own model of the
// engine for every request it sends. That model covers the start, stop, byte
// write, byte read, ack send and ack receive sequences, commands refused while
// busy, and the unused command code. The expected result is queued when the
// request is accepted. Each result that comes out is compared field by field
// with the oldest queued entry.
// A short directed table runs first. A random run follows, under three
// idling phases, with one long receiver hold-off so that the block fills and
// stalls its input.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RSVD    = 3'd7;
    localparam int         RAND_ITEMS  = 1250;
    localparam int         HOLD_CYCLES = 60;
    localparam int         DRAIN_CYC   = 20;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       scl;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] rd_data;
        logic       ack_in;
        logic       rejected;
    } t_slot_res;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wr_data;
        logic       ack_out;
        logic       sda_in;
        logic [4:0] slots;
        logic       typed;
        t_slot_res  res;
    } t_dir_row;

    localparam t_slot_res RES_NONE  = '0;
    localparam t_slot_res RES_RESET = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam t_slot_res RES_REJ   = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

    localparam int DIR_ROWS = 21;
    // the first slot of a row carries its command, the rest carry none
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{i2cms_pkg::OP_IDLE,  8'h00, 1'b0, 1'b0, 5'd1,  1'b1, RES_RESET},
        '{CMD_RSVD,            8'hFF, 1'b1, 1'b1, 5'd1,  1'b1, RES_RESET},
        '{i2cms_pkg::OP_START, 8'h00, 1'b0, 1'b0, 5'd1,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_STOP,  8'hFF, 1'b1, 1'b1, 5'd1,  1'b1, RES_REJ},
        '{i2cms_pkg::OP_IDLE,  8'h00, 1'b0, 1'b0, 5'd2,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0, 5'd24, 1'b0, RES_NONE},
        '{i2cms_pkg::OP_RACK,  8'h00, 1'b1, 1'b0, 5'd4,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_WRITE, 8'h00, 1'b1, 1'b1, 5'd24, 1'b0, RES_NONE},
        '{i2cms_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 5'd25, 1'b0, RES_NONE},
        '{i2cms_pkg::OP_SACK,  8'h00, 1'b0, 1'b0, 5'd3,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_READ,  8'hFF, 1'b1, 1'b0, 5'd25, 1'b0, RES_NONE},
        '{i2cms_pkg::OP_SACK,  8'hFF, 1'b1, 1'b1, 5'd3,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_RACK,  8'h00, 1'b0, 1'b1, 5'd4,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b1, 5'd1,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_RACK,  8'h5A, 1'b1, 1'b0, 5'd1,  1'b0, RES_NONE},
        '{CMD_RSVD,            8'h00, 1'b0, 1'b1, 5'd1,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_WRITE, 8'h3C, 1'b1, 1'b1, 5'd1,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_IDLE,  8'h00, 1'b0, 1'b0, 5'd20, 1'b0, RES_NONE},
        '{i2cms_pkg::OP_STOP,  8'h00, 1'b0, 1'b0, 5'd3,  1'b0, RES_NONE},
        '{CMD_RSVD,            8'h00, 1'b0, 1'b0, 5'd1,  1'b0, RES_NONE},
        '{i2cms_pkg::OP_IDLE,  8'hFF, 1'b1, 1'b1, 5'd2,  1'b0, RES_NONE}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [2:0] i_cmd       = '0;
    logic [7:0] i_wr_data   = '0;
    logic       i_ack_out   = 1'b0;
    logic       i_sda_in    = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_scl;
    logic       o_sda_drive;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rd_data;
    logic       o_ack_in;
    logic       o_rejected;

    // engine model state
    i2cms_pkg::t_op eng_op    = i2cms_pkg::OP_IDLE;
    logic [4:0]     eng_slot  = '0;
    logic [7:0]     eng_shift = '0;
    logic           eng_scl   = 1'b1;
    logic           eng_sda   = 1'b1;
    logic           eng_ack   = 1'b0;
    logic [7:0]     eng_rd    = '0;

    t_slot_res  slot_exp_q[$];
    int         mismatches = 0;
    int         idle_phase = 0;
    int         cyc_cnt    = 0;
    int         hold_left  = 0;
    logic       hold_req   = 1'b0;
    logic       hold_taken = 1'b0;

    i2c_master_bit_sequencer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_wr_data   (i_wr_data),
        .i_ack_out   (i_ack_out),
        .i_sda_in    (i_sda_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_scl       (o_scl),
        .o_sda_drive (o_sda_drive),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rd_data   (o_rd_data),
        .o_ack_in    (o_ack_in),
        .o_rejected  (o_rejected)
    );

    always #10 i_clk = ~i_clk;

    function automatic int op_slots(input i2cms_pkg::t_op op);
        case (op)
            i2cms_pkg::OP_START: return 4;
            i2cms_pkg::OP_STOP:  return 3;
            i2cms_pkg::OP_WRITE: return 24;
            i2cms_pkg::OP_READ:  return 25;
            i2cms_pkg::OP_SACK:  return 3;
            i2cms_pkg::OP_RACK:  return 4;
            default:             return 0;
        endcase
    endfunction

    function automatic t_slot_res engine_slot(input logic [2:0] cmd, input logic [7:0] wr,
                                              input logic ack, input logic sda);
        t_slot_res r;
        int        s;
        int        bi;
        int        ph;
        r = '0;
        if (eng_op == i2cms_pkg::OP_IDLE) begin
            if (cmd != i2cms_pkg::OP_IDLE && cmd != CMD_RSVD) begin
                eng_op    = i2cms_pkg::t_op'(cmd);
                eng_slot  = '0;
                eng_shift = (cmd == i2cms_pkg::OP_WRITE) ? wr : 8'h00;
            end
        end else if (cmd != i2cms_pkg::OP_IDLE) begin
            r.rejected = 1'b1;
        end
        if (eng_op != i2cms_pkg::OP_IDLE) begin
            s = int'(eng_slot);
            case (eng_op)
                i2cms_pkg::OP_START: begin
                    case (s)
                        0:       eng_sda = 1'b1;
                        1:       eng_scl = 1'b1;
                        2:       eng_sda = 1'b0;
                        default: eng_scl = 1'b0;
                    endcase
                end
                i2cms_pkg::OP_STOP: begin
                    case (s)
                        0:       eng_sda = 1'b0;
                        1:       eng_scl = 1'b1;
                        default: eng_sda = 1'b1;
                    endcase
                end
                i2cms_pkg::OP_WRITE: begin
                    bi = s / 3;
                    ph = s % 3;
                    if (ph == 0) eng_sda = eng_shift[7 - bi];
                    else eng_scl = (ph == 1);
                end
                i2cms_pkg::OP_READ: begin
                    if (s == 0) begin
                        eng_sda = 1'b1;
                    end else begin
                        bi = (s - 1) / 3;
                        ph = (s - 1) % 3;
                        if (ph == 0) eng_scl = 1'b1;
                        else if (ph == 1) begin
                            if (sda) eng_shift[7 - bi] = 1'b1;
                        end else eng_scl = 1'b0;
                    end
                end
                i2cms_pkg::OP_SACK: begin
                    case (s)
                        0:       eng_sda = ack;
                        1:       eng_scl = 1'b1;
                        default: eng_scl = 1'b0;
                    endcase
                end
                i2cms_pkg::OP_RACK: begin
                    case (s)
                        0:       eng_sda = 1'b1;
                        1:       eng_scl = 1'b1;
                        2:       eng_ack = sda;
                        default: eng_scl = 1'b0;
                    endcase
                end
                default: ;
            endcase
            if (s + 1 >= op_slots(eng_op)) begin
                if (eng_op == i2cms_pkg::OP_READ) eng_rd = eng_shift;
                r.done   = 1'b1;
                eng_op   = i2cms_pkg::OP_IDLE;
                eng_slot = '0;
            end else begin
                eng_slot = eng_slot + 5'd1;
            end
        end
        r.scl       = eng_scl;
        r.sda_drive = eng_sda;
        r.busy      = (eng_op != i2cms_pkg::OP_IDLE);
        r.rd_data   = eng_rd;
        r.ack_in    = eng_ack;
        return r;
    endfunction

    function automatic int src_idle_pct();
        return (idle_phase == 0) ? 18 : (idle_phase == 1) ? 47 : 0;
    endfunction

    function automatic int dst_idle_pct();
        return (idle_phase == 0) ? 47 : (idle_phase == 1) ? 18 : 0;
    endfunction

    task automatic send_slot(input logic [2:0] cmd, input logic [7:0] wr, input logic ack,
                             input logic sda, input t_slot_res res);
        while ($urandom_range(99) < src_idle_pct()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_wr_data <= wr;
        i_ack_out <= ack;
        i_sda_in  <= sda;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        slot_exp_q.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
        end
    endtask

    // receiver side: random stall plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < dst_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        t_slot_res exp_r;
        t_slot_res act_r;
        if (i_rst_n && o_valid && !i_stall) begin
            act_r = '{o_scl, o_sda_drive, o_busy_res, o_done_res, o_rd_data, o_ack_in,
                      o_rejected};
            if (slot_exp_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, actual %0h", $realtime, act_r);
            end else begin
                exp_r = slot_exp_q.pop_front();
                check_field("scl", 8'(exp_r.scl), 8'(act_r.scl));
                check_field("sda_drive", 8'(exp_r.sda_drive), 8'(act_r.sda_drive));
                check_field("busy", 8'(exp_r.busy), 8'(act_r.busy));
                check_field("done", 8'(exp_r.done), 8'(act_r.done));
                check_field("rd_data", exp_r.rd_data, act_r.rd_data);
                check_field("ack_in", 8'(exp_r.ack_in), 8'(act_r.ack_in));
                check_field("rejected", 8'(exp_r.rejected), 8'(act_r.rejected));
            end
        end
    end

    initial begin
        while (cyc_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_slot_res  res;
        logic [2:0] cmd;
        logic [7:0] wr;
        logic       ack;
        logic       sda;
        int         roll;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < int'(DIR_TAB[r].slots); k++) begin
                cmd = (k == 0) ? DIR_TAB[r].cmd : i2cms_pkg::OP_IDLE;
                res = engine_slot(cmd, DIR_TAB[r].wr_data, DIR_TAB[r].ack_out,
                                  DIR_TAB[r].sda_in);
                if (DIR_TAB[r].typed) res = DIR_TAB[r].res;
                send_slot(cmd, DIR_TAB[r].wr_data, DIR_TAB[r].ack_out, DIR_TAB[r].sda_in, res);
            end
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) idle_phase = 1;
            if (n == 2 * RAND_ITEMS / 3) idle_phase = 2;
            if (n == 2 * RAND_ITEMS / 3 + 20) hold_req = 1'b1;
            wr   = 8'($urandom_range(255));
            ack  = 1'($urandom_range(1));
            sda  = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (eng_op == i2cms_pkg::OP_IDLE) begin
                if (roll < 8) cmd = i2cms_pkg::OP_IDLE;
                else if (roll < 12) cmd = CMD_RSVD;
                else cmd = 3'($urandom_range(6, 1));
            end else begin
                cmd = (roll < 6) ? 3'($urandom_range(7, 1)) : i2cms_pkg::OP_IDLE;
            end
            res = engine_slot(cmd, wr, ack, sda);
            send_slot(cmd, wr, ack, sda, res);
        end
        i_valid <= 1'b0;

        while (slot_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
